// ===== rtl/core/pal_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the positional array list core.
package pal_pkg;

    localparam int WORD_W        = 32;
    localparam int ACT_W         = 2;
    localparam int POS_W         = 4;
    localparam int STAT_W        = 2;
    localparam int CNT_OUT_W     = 5;
    localparam int CAP_W         = 5;
    localparam int STORE_DEPTH_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } cell_op_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        cell_op_t          op;
        logic [WORD_W-1:0] value;
    } cell_cmd_t;

endpackage

// ===== rtl/core/pal_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the list chain, holding the entry at a fixed position.
module pal_cell #(
    parameter int IW  = 4,
    parameter int IDX = 0
) (
    input  logic                       clk,
    input  pal_pkg::cell_cmd_t         cmd,
    input  logic [IW-1:0]              pos,
    input  logic [pal_pkg::WORD_W-1:0] lower_word,
    input  logic [pal_pkg::WORD_W-1:0] upper_word,
    output logic [pal_pkg::WORD_W-1:0] word
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [pal_pkg::WORD_W-1:0] data_reg;
    logic [pal_pkg::WORD_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.op)
            pal_pkg::CELL_INSERT:
            begin
                // Cells above the insert point take their lower neighbor.
                if (MY_IDX > pos)
                begin
                    data_next = lower_word;
                end
                else if (MY_IDX == pos)
                begin
                    data_next = cmd.value;
                end
            end
            pal_pkg::CELL_DELETE:
            begin
                if (MY_IDX >= pos)
                begin
                    data_next = upper_word;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign word = data_reg;

endmodule

// ===== rtl/core/positional_array_list_core.sv =====
`timescale 1ns / 1ps
// Top level of the positional array list core: control, cell chain and result register.
//
// An ordered list of 32-bit words held in a chain of STORE_DEPTH cells.
// Issue an item by raising start with action, position and value; it is
// taken at the clock edge where start is high and busy is low. Busy never
// rises in this design, so one item is taken every cycle.
// Actions: insert (later entries move up one cell, a position at or past
// the count appends), delete (later entries move down, the removed word is
// returned), read, and clear.
// Each item gives one result in the cycle after it is taken: done is high for
// exactly that cycle with word_out, status and count_after. The receiver
// cannot stall; a result not taken in that cycle is overwritten by the next item.
// Throughput is one item per cycle: every cell moves in parallel, and the read
// word comes from one mux over the cells.
// The capacity register is written with cfg_we and cfg_wdata; the user must write
// it only while no item is in flight, as the block itself does not enforce this.
// Values above STORE_DEPTH act as STORE_DEPTH. Reset clears the count to zero and
// the capacity to ten; entry contents are left as they are.
module positional_array_list_core #(
    parameter int STORE_DEPTH = pal_pkg::STORE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pal_pkg::ACT_W-1:0]     action,
    input  logic [pal_pkg::POS_W-1:0]     position,
    input  logic [pal_pkg::WORD_W-1:0]    value,
    input  logic                          cfg_we,
    input  logic [pal_pkg::CAP_W-1:0]     cfg_wdata,
    output logic                          done,
    output logic [pal_pkg::WORD_W-1:0]    word_out,
    output logic [pal_pkg::STAT_W-1:0]    status,
    output logic [pal_pkg::CNT_OUT_W-1:0] count_after
);

    localparam int IW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW    = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W = (CW > pal_pkg::CAP_W) ? CW : pal_pkg::CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(STORE_DEPTH);

    logic [pal_pkg::CAP_W-1:0]     cap_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          done_reg;
    logic [pal_pkg::WORD_W-1:0]    word_reg;
    logic [pal_pkg::WORD_W-1:0]    word_next;
    pal_pkg::status_t              status_reg;
    pal_pkg::status_t              status_next;
    logic [pal_pkg::CNT_OUT_W-1:0] count_out_reg;

    logic [CMP_W-1:0]              cap_c;
    logic [CMP_W-1:0]              eff_cap;
    logic [CMP_W-1:0]              count_c;
    logic [CMP_W-1:0]              pos_c;
    logic                          full;
    logic                          in_range;
    logic [IW-1:0]                 pos_idx;
    logic [IW-1:0]                 cell_pos;
    logic [pal_pkg::WORD_W-1:0]    sel_word;
    pal_pkg::cell_cmd_t            cmd;
    pal_pkg::action_t              act;

    logic [pal_pkg::WORD_W-1:0]    cell_word [STORE_DEPTH];

    assign act      = pal_pkg::action_t'(action);
    assign cap_c    = CMP_W'(cap_reg);
    assign eff_cap  = (cap_c > DEPTH_C) ? DEPTH_C : cap_c;
    assign count_c  = CMP_W'(count_reg);
    assign pos_c    = CMP_W'(position);
    assign full     = count_c >= eff_cap;
    assign in_range = pos_c < count_c;
    assign pos_idx  = pos_c[IW-1:0];
    assign sel_word = cell_word[pos_idx];

    always_comb
    begin
        cmd.op      = pal_pkg::CELL_HOLD;
        cmd.value   = value;
        cell_pos    = pos_idx;
        count_next  = count_reg;
        word_next   = '0;
        status_next = pal_pkg::ST_DONE;
        unique case (act)
            pal_pkg::ACT_INSERT:
            begin
                if (full)
                begin
                    status_next = pal_pkg::ST_FULL;
                end
                else
                begin
                    // Not full means the count is below the depth, so it fits the index.
                    cell_pos   = in_range ? pos_idx : count_c[IW-1:0];
                    cmd.op     = start ? pal_pkg::CELL_INSERT : pal_pkg::CELL_HOLD;
                    count_next = count_reg + CW'(1);
                    word_next  = value;
                end
            end
            pal_pkg::ACT_DELETE:
            begin
                if (!in_range)
                begin
                    status_next = pal_pkg::ST_RANGE;
                end
                else
                begin
                    cmd.op     = start ? pal_pkg::CELL_DELETE : pal_pkg::CELL_HOLD;
                    count_next = count_reg - CW'(1);
                    word_next  = sel_word;
                end
            end
            pal_pkg::ACT_READ:
            begin
                if (!in_range)
                begin
                    status_next = pal_pkg::ST_RANGE;
                end
                else
                begin
                    word_next = sel_word;
                end
            end
            pal_pkg::ACT_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < STORE_DEPTH; g++)
        begin : g_cell
            logic [pal_pkg::WORD_W-1:0] lower_w;
            logic [pal_pkg::WORD_W-1:0] upper_w;

            if (g == 0)
            begin : g_first
                assign lower_w = value;
            end
            else
            begin : g_mid_lo
                assign lower_w = cell_word[g-1];
            end

            if (g == STORE_DEPTH - 1)
            begin : g_last
                assign upper_w = cell_word[g];
            end
            else
            begin : g_mid_hi
                assign upper_w = cell_word[g+1];
            end

            pal_cell #(
                .IW  (IW),
                .IDX (g)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .pos        (cell_pos),
                .lower_word (lower_w),
                .upper_word (upper_w),
                .word       (cell_word[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= pal_pkg::CAP_RESET;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (start)
            begin
                count_reg <= count_next;
            end
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            word_reg      <= word_next;
            status_reg    <= status_next;
            count_out_reg <= pal_pkg::CNT_OUT_W'(count_next);
        end
    end

    assign busy        = 1'b0;
    assign done        = done_reg;
    assign word_out    = word_reg;
    assign status      = status_reg;
    assign count_after = count_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= DEPTH_C)
        else $error("entry count exceeds store depth");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done_reg)
        else $error("accepted item gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |=> !done_reg)
        else $error("result without an accepted item");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (start && act == pal_pkg::ACT_CLEAR) |=> (count_reg == '0))
        else $error("clear left entries in the list");

    a_refused_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (status_next == pal_pkg::ST_FULL || status_next == pal_pkg::ST_RANGE))
        |=> (count_reg == $past(count_reg)))
        else $error("refused action changed the count");

endmodule
